/* hw/rtl/isr_pkg.sv */
// Shared types and constants for the impulse-ring input shaper.
`timescale 1ns / 1ps

package isr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int AMP_W     = 16;
  localparam int DLY_W     = 10;
  localparam int CNT_W     = 2;
  localparam int PROD_W    = SAMPLE_W + AMP_W + 1;
  localparam int ACC_W     = 34;
  localparam int FRAC_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMPULSE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FIRST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_SECOND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THIRD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SECOND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_THIRD   = 3'd5;

  // Impulse count code that enables the third impulse
  localparam logic [CNT_W-1:0] COUNT_THREE = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef struct packed {
    logic [CNT_W-1:0] impulse_count;
    logic [AMP_W-1:0] amp_first;
    logic [AMP_W-1:0] amp_second;
    logic [AMP_W-1:0] amp_third;
    logic [DLY_W-1:0] delay_second;
    logic [DLY_W-1:0] delay_third;
  } cfg_t;

  // Per-item sequencer phases
  typedef enum logic [2:0] {
    SEQ_WAIT,
    SEQ_SUM,
    SEQ_RD3,
    SEQ_RDC,
    SEQ_DONE
  } seq_state_t;

endpackage

/* hw/rtl/isr_if.sv */
// Valid/ready channel interfaces for command samples and shaped results.
`timescale 1ns / 1ps

interface isr_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  command_sample;

  modport source (output valid, output command_sample, input ready);
  modport sink (input valid, input command_sample, output ready);
endinterface

interface isr_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  shaped_sample;
  logic                saturated;

  modport source (output valid, output shaped_sample, output saturated, input ready);
  modport sink (input valid, input shaped_sample, input saturated, output ready);
endinterface

/* hw/rtl/input_shaper_impulse_ring.sv */
// Top level of the impulse-ring input shaper.
//
// Takes one signed command sample per transfer on in_ch and returns one shaped
// sample with a clip flag per transfer on out_ch. Each sample is weighted by
// two or three unsigned Q1.15 impulse amplitudes and added into a ring of 34-bit
// accumulators at the programmed delays; the current slot is then read out,
// shifted right by 15, clipped to 16 bits and cleared.
// Each item runs through the sequencer phases SUM, RD3, RDC and DONE, paced
// by the ring memory's one read and one write port: second-impulse RMW,
// third-impulse RMW, read-out and clear of the current slot.
// An input register takes the next sample while the current one is in work,
// and an output register holds a result until it is taken; when the receiver
// stalls, the sequencer waits in its final phase and input fills then stops.
// After reset the ring is cleared one entry a cycle, with in_ch.ready low;
// configuration writes are taken throughout. Write the
// registers only while no item is in work.
`timescale 1ns / 1ps

module input_shaper_impulse_ring
  import isr_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  isr_in_if.sink               in_ch,
  isr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);

  cfg_t             cfg;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [ACC_W-1:0] mem_wdata, mem_rdata;

  isr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  isr_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .DW    (ACC_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  isr_core #(
    .AW (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.command_sample),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.shaped_sample),
    .out_sat    (out_ch.saturated),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

/* hw/rtl/isr_cfg_regs.sv */
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps

module isr_cfg_regs
  import isr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and update the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMPULSE_COUNT: cfg_nxt.impulse_count = cfg_wdata[CNT_W-1:0];
        REG_AMP_FIRST:     cfg_nxt.amp_first     = cfg_wdata[AMP_W-1:0];
        REG_AMP_SECOND:    cfg_nxt.amp_second    = cfg_wdata[AMP_W-1:0];
        REG_AMP_THIRD:     cfg_nxt.amp_third     = cfg_wdata[AMP_W-1:0];
        REG_DELAY_SECOND:  cfg_nxt.delay_second  = cfg_wdata[DLY_W-1:0];
        REG_DELAY_THIRD:   cfg_nxt.delay_third   = cfg_wdata[DLY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.impulse_count <= CNT_W'(2);
      cfg_r.amp_first     <= AMP_W'(16384);
      cfg_r.amp_second    <= AMP_W'(16384);
      cfg_r.amp_third     <= '0;
      cfg_r.delay_second  <= '0;
      cfg_r.delay_third   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/isr_ring_mem.sv */
// Accumulator ring memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module isr_ring_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 34
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Store the write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read, hold it while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/isr_core.sv */
// Input stage, read-modify-write sequencer, clearing pass and output register.
`timescale 1ns / 1ps

module isr_core
  import isr_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_sat,
  // ring memory
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ACC_W-1:0]           mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ACC_W-1:0]           mem_rdata
);

  localparam int SUM_W = (AW > DLY_W) ? AW : DLY_W;

  seq_state_t state_r, state_nxt;

  logic                       in_full_r;
  logic signed [PROD_W-1:0]   p1_r, p2_r, p3_r;
  logic [AW-1:0]              cur_r, s2_r, s3_r;
  logic                       act2_r, act3_r;
  logic signed [ACC_W-1:0]    add_cur_r, add_s2_r, add_s3_r;
  logic                       clr_busy_r;
  logic [AW-1:0]              clr_addr_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sat_r;

  logic                       in_take, in_xfer, out_free, third_on;
  logic [SUM_W-1:0]           sum2, sum3;
  logic [AW-1:0]              s2_c, s3_c;
  logic                       hit2cur, hit3cur, hit32;
  logic signed [ACC_W-1:0]    p1x, p2x, p3x;
  logic signed [ACC_W-1:0]    acc_c;
  logic                       sat_c;
  logic signed [SAMPLE_W-1:0] shaped_c;

  // Input handshake: the input register refills while the sequencer drains it
  assign in_take  = (state_r == SEQ_SUM);
  assign in_ready = !clr_busy_r && (!in_full_r || in_take);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign third_on = (cfg.impulse_count == COUNT_THREE);

  // Target slots of the delayed impulses, wrapped to the AW-bit ring address
  assign sum2 = SUM_W'(cur_r) + SUM_W'(cfg.delay_second);
  assign sum3 = SUM_W'(cur_r) + SUM_W'(cfg.delay_third);
  assign s2_c = sum2[AW-1:0];
  assign s3_c = sum3[AW-1:0];

  // Merge impulses that land on the same slot
  assign hit2cur = (s2_c == cur_r);
  assign hit3cur = third_on && (s3_c == cur_r);
  assign hit32   = third_on && (s3_c == s2_c);

  assign p1x = ACC_W'(p1_r);
  assign p2x = ACC_W'(p2_r);
  assign p3x = ACC_W'(p3_r);

  // Current slot after all additions, floor shift and clip
  assign acc_c = $signed(mem_rdata) + add_cur_r;
  always_comb begin
    sat_c    = (acc_c[ACC_W-1:ACC_W-4] != {4{acc_c[ACC_W-4]}});
    shaped_c = acc_c[FRAC_W+SAMPLE_W-1:FRAC_W];
    if (sat_c) begin
      shaped_c = acc_c[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  // Sequencer next state and memory port control
  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    mem_raddr = cur_r;
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = '0;
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end
    unique case (state_r)
      SEQ_WAIT: begin
        if (in_full_r || in_xfer) state_nxt = SEQ_SUM;
      end
      SEQ_SUM: begin
        mem_re    = 1'b1;
        mem_raddr = s2_c;
        state_nxt = SEQ_RD3;
      end
      SEQ_RD3: begin
        mem_re    = 1'b1;
        mem_raddr = s3_r;
        mem_we    = act2_r;
        mem_waddr = s2_r;
        mem_wdata = mem_rdata + add_s2_r;
        state_nxt = SEQ_RDC;
      end
      SEQ_RDC: begin
        mem_re    = 1'b1;
        mem_raddr = cur_r;
        mem_we    = act3_r;
        mem_waddr = s3_r;
        mem_wdata = mem_rdata + add_s3_r;
        state_nxt = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          mem_wdata = '0;
          state_nxt = (in_full_r || in_xfer) ? SEQ_SUM : SEQ_WAIT;
        end
      end
      default: state_nxt = SEQ_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted sample as its three weighted products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_xfer) begin
      in_full_r <= 1'b1;
    end else if (in_take) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p1_r <= PROD_W'(in_sample) * PROD_W'($signed({1'b0, cfg.amp_first}));
      p2_r <= PROD_W'(in_sample) * PROD_W'($signed({1'b0, cfg.amp_second}));
      p3_r <= PROD_W'(in_sample) * PROD_W'($signed({1'b0, cfg.amp_third}));
    end
  end

  // Latch slot addresses and merged addends for the item
  always_ff @(posedge clk) begin
    if (in_take) begin
      s2_r      <= s2_c;
      s3_r      <= s3_c;
      act2_r    <= !hit2cur;
      act3_r    <= third_on && !hit3cur && !hit32;
      add_cur_r <= p1x + (hit2cur ? p2x : '0) + (hit3cur ? p3x : '0);
      add_s2_r  <= p2x + (hit32 ? p3x : '0);
      add_s3_r  <= p3x;
    end
  end

  // Advance the ring pointer when the current slot is read out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (state_r == SEQ_DONE && out_free) begin
      cur_r <= cur_r + 1'b1;
    end
  end

  // Clearing pass over the whole ring after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {AW{1'b1}}) clr_busy_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == SEQ_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == SEQ_DONE && out_free) begin
      out_sample_r <= shaped_c;
      out_sat_r    <= sat_c;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_sat    = out_sat_r;

endmodule

/* hw/rtl/isr_checker.sv */
// Port-level assertions for the impulse-ring input shaper, bound to the top level.
`timescale 1ns / 1ps

module isr_checker
  import isr_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] shaped_sample,
  input logic                       saturated
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(shaped_sample) && $stable(saturated))
    else $error("stalled result changed");

  // A clipped result sits at one end of the 16-bit range
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> shaped_sample == SAMPLE_MAX || shaped_sample == SAMPLE_MIN)
    else $error("clip flag without a clipped value");

  // The ring clear keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input open during ring clear");

  // Two transfers in a row fill the input register and the sequencer
  a_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && $past(in_valid && in_ready) && $past(rst_n) |=> !in_ready)
    else $error("input open with sequencer and input register full");

  // No result during reset or on the first cycle after it
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind input_shaper_impulse_ring isr_checker u_isr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .shaped_sample (out_ch.shaped_sample),
  .saturated     (out_ch.saturated)
);
